FILE: rtl/psd_pkg.sv
// Package: payload types, widths and the pipeline stage record for the point-segment distance unit.
package psd_pkg;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned SqBits    = 2 * DiffBits + 1;
  localparam int unsigned TBits     = 16;
  localparam int unsigned TOutBits  = TBits + 1;
  localparam int unsigned DistBits  = CoordBits + 1;
  localparam int unsigned DivStages = TBits;
  localparam int unsigned SqrtSteps = SqBits / 2 + 1;
  localparam int unsigned RootBits  = SqrtSteps;
  localparam int unsigned RemBits   = RootBits + 2;

  typedef struct packed {
    logic signed [CoordBits-1:0] seg_start_x;
    logic signed [CoordBits-1:0] seg_start_y;
    logic signed [CoordBits-1:0] seg_end_x;
    logic signed [CoordBits-1:0] seg_end_y;
    logic signed [CoordBits-1:0] query_x;
    logic signed [CoordBits-1:0] query_y;
  } psd_in_t;

  typedef struct packed {
    logic [DistBits-1:0] distance;
    logic [TOutBits-1:0] projection_param;
    logic                degenerate;
  } psd_out_t;

  typedef struct packed {
    logic signed [DiffBits-1:0] dx;
    logic signed [DiffBits-1:0] dy;
    logic signed [DiffBits-1:0] wx;
    logic signed [DiffBits-1:0] wy;
  } psd_vec_t;
endpackage

FILE: rtl/psd_div.sv
// Pipelined restoring divider: t = floor(dot * 2^16 / len2), one quotient bit per stage.
module psd_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [psd_pkg::SqBits-1:0]  num_i,
  input  logic [psd_pkg::SqBits-1:0]  den_i,
  output logic [psd_pkg::TBits-1:0]   quo_o
);
  import psd_pkg::*;
  // num < den on entry, so remainder stays below den
  logic [SqBits-1:0] rem_q [DivStages];
  logic [SqBits-1:0] den_q [DivStages];
  logic [TBits-1:0]  quo_q [DivStages];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DivStages; i++) begin
      if (en_i) begin
        logic [SqBits:0]   sh;
        logic [SqBits-1:0] r;
        logic [SqBits-1:0] d;
        logic [TBits-1:0]  qv;
        r  = (i == 0) ? num_i : rem_q[i-1];
        d  = (i == 0) ? den_i : den_q[i-1];
        qv = (i == 0) ? '0 : quo_q[i-1];
        sh = {r, 1'b0};
        if (sh >= {1'b0, d}) begin
          rem_q[i] <= SqBits'(sh - {1'b0, d});
          quo_q[i] <= {qv[TBits-2:0], 1'b1};
        end else begin
          rem_q[i] <= sh[SqBits-1:0];
          quo_q[i] <= {qv[TBits-2:0], 1'b0};
        end
        den_q[i] <= d;
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];
endmodule

FILE: rtl/psd_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
module psd_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [psd_pkg::SqBits-1:0]   val_i,
  output logic [psd_pkg::RootBits-1:0] root_o
);
  import psd_pkg::*;
  localparam int unsigned PadBits = 2 * SqrtSteps;
  logic [PadBits-1:0]  val_q  [SqrtSteps];
  logic [RemBits-1:0]  rem_q  [SqrtSteps];
  logic [RootBits-1:0] root_q [SqrtSteps];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SqrtSteps; i++) begin
      if (en_i) begin
        logic [PadBits-1:0]  v;
        logic [RemBits-1:0]  r;
        logic [RootBits-1:0] q;
        logic [RemBits-1:0]  trial;
        logic [RemBits-1:0]  cand;
        v = (i == 0) ? PadBits'(val_i) : val_q[i-1];
        r = (i == 0) ? '0 : rem_q[i-1];
        q = (i == 0) ? '0 : root_q[i-1];
        trial = {r[RemBits-3:0], v[PadBits-1 -: 2]};
        cand  = {q, 2'b01};
        if (trial >= cand) begin
          rem_q[i]  <= trial - cand;
          root_q[i] <= {q[RootBits-2:0], 1'b1};
        end else begin
          rem_q[i]  <= trial;
          root_q[i] <= {q[RootBits-2:0], 1'b0};
        end
        val_q[i] <= {v[PadBits-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SqrtSteps-1];
endmodule

FILE: rtl/point_segment_distance_unit.sv
// Top level: point to segment distance pipeline with divide and square root units.
// Pipeline order: differences, products, len2 and dot, divide, final t, error vector, squared error, square root.
// Throughput: one item per cycle; every stage is pipelined, a stall freezes the whole pipe.
// The output register takes a new result while the previous one is taken in the same cycle.
// Reset: asynchronous, active low, clears all valid bits; data registers are not reset.
module point_segment_distance_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  psd_pkg::psd_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output psd_pkg::psd_out_t  out_data_o
);
  import psd_pkg::*;
  localparam int unsigned Lat = 3 + DivStages + 3 + SqrtSteps;
  localparam logic [TOutBits-1:0] TOne = TOutBits'(1) << TBits;

  logic en;
  logic [Lat-1:0] vld_q;
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // stage 1: differences
  psd_vec_t v1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      v1_q.dx <= DiffBits'(in_data_i.seg_end_x) - DiffBits'(in_data_i.seg_start_x);
      v1_q.dy <= DiffBits'(in_data_i.seg_end_y) - DiffBits'(in_data_i.seg_start_y);
      v1_q.wx <= DiffBits'(in_data_i.query_x) - DiffBits'(in_data_i.seg_start_x);
      v1_q.wy <= DiffBits'(in_data_i.query_y) - DiffBits'(in_data_i.seg_start_y);
    end
  end

  // stage 2: products
  psd_vec_t v2_q;
  logic signed [SqBits-1:0] pdx_q, pdy_q, pwx_q, pwy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      v2_q  <= v1_q;
      pdx_q <= SqBits'(v1_q.dx * v1_q.dx);
      pdy_q <= SqBits'(v1_q.dy * v1_q.dy);
      pwx_q <= SqBits'(v1_q.wx * v1_q.dx);
      pwy_q <= SqBits'(v1_q.wy * v1_q.dy);
    end
  end

  // stage 3: len2, dot, clamp decision
  psd_vec_t v3_q;
  logic [SqBits-1:0] len2_q, dot_q;
  logic degen3_q, lo3_q, hi3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [SqBits-1:0] l2;
      logic signed [SqBits:0] dt;
      l2 = SqBits'(pdx_q) + SqBits'(pdy_q);
      dt = (SqBits+1)'(pwx_q) + (SqBits+1)'(pwy_q);
      v3_q     <= v2_q;
      len2_q   <= l2;
      dot_q    <= dt[SqBits-1:0];
      degen3_q <= (l2 == '0);
      lo3_q    <= (dt <= 0);
      hi3_q    <= (dt >= $signed({1'b0, l2}));
    end
  end

  logic [TBits-1:0] quo;
  psd_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ((lo3_q || hi3_q) ? '0 : dot_q),
    .den_i (degen3_q ? SqBits'(1) : len2_q),
    .quo_o (quo)
  );

  psd_vec_t vd_q [DivStages];
  logic [2:0] fl_q [DivStages];
  always_ff @(posedge clk_i) begin
    if (en) begin
      vd_q[0] <= v3_q;
      fl_q[0] <= {degen3_q, lo3_q, hi3_q};
      for (int i = 1; i < DivStages; i++) begin
        vd_q[i] <= vd_q[i-1];
        fl_q[i] <= fl_q[i-1];
      end
    end
  end

  // stage A: final t
  psd_vec_t va_q;
  logic [TOutBits-1:0] ta_q;
  logic degena_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [2:0] f;
      f = fl_q[DivStages-1];
      va_q     <= vd_q[DivStages-1];
      degena_q <= f[2];
      if (f[2] || f[1])  ta_q <= '0;
      else if (f[0])     ta_q <= TOne;
      else               ta_q <= TOutBits'(quo);
    end
  end

  // stage B: error vector
  logic signed [DiffBits:0] exb_q, eyb_q;
  logic [TOutBits-1:0] tb_q;
  logic degenb_q;
  function automatic logic signed [DiffBits:0] err_f(
    input logic [TOutBits-1:0] t, input logic signed [DiffBits-1:0] d,
    input logic signed [DiffBits-1:0] w);
    logic signed [TOutBits+DiffBits:0] p;
    logic [TOutBits+DiffBits:0] m;
    logic signed [DiffBits:0] o;
    p = $signed({1'b0, t}) * d;
    m = p[TOutBits+DiffBits] ? -p : p;
    o = (DiffBits+1)'(m >> TBits);
    if (p[TOutBits+DiffBits]) o = -o;
    return (DiffBits+1)'(w) - o;
  endfunction
  always_ff @(posedge clk_i) begin
    if (en) begin
      exb_q    <= err_f(ta_q, va_q.dx, va_q.wx);
      eyb_q    <= err_f(ta_q, va_q.dy, va_q.wy);
      tb_q     <= ta_q;
      degenb_q <= degena_q;
    end
  end

  // stage C: squared length of error
  logic [SqBits-1:0] sqc_q;
  logic [TOutBits-1:0] tc_q;
  logic degenc_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic signed [2*DiffBits+1:0] a, b;
      a = exb_q * exb_q;
      b = eyb_q * eyb_q;
      sqc_q    <= SqBits'(a + b);
      tc_q     <= tb_q;
      degenc_q <= degenb_q;
    end
  end

  logic [RootBits-1:0] root;
  psd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (sqc_q),
    .root_o (root)
  );

  logic [TOutBits-1:0] ts_q [SqrtSteps];
  logic ds_q [SqrtSteps];
  always_ff @(posedge clk_i) begin
    if (en) begin
      ts_q[0] <= tc_q;
      ds_q[0] <= degenc_q;
      for (int i = 1; i < SqrtSteps; i++) begin
        ts_q[i] <= ts_q[i-1];
        ds_q[i] <= ds_q[i-1];
      end
    end
  end

  always_comb begin
    out_data_o.projection_param = ts_q[SqrtSteps-1];
    out_data_o.degenerate       = ds_q[SqrtSteps-1];
    if (root > RootBits'({DistBits{1'b1}})) out_data_o.distance = '1;
    else out_data_o.distance = root[DistBits-1:0];
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.projection_param <= TOne)
    else $error("projection parameter above one");
  a_degen_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.projection_param == '0)
    else $error("degenerate segment with nonzero t");
endmodule

FILE: verif/point_segment_distance_unit_tb.sv
// Testbench for the point to segment distance unit: directed geometry cases, random streams, stall pressure.
`timescale 1ns / 100ps
module point_segment_distance_unit_tb;
  import psd_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  psd_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  psd_out_t out_data_o;

  psd_out_t distance_queue[$];
  int       mismatches = 0;
  bit       stall_random = 1'b1;
  bit       hold_off = 1'b0;
  bit       send_gaps = 1'b1;
  int       recv_wait = 0;

  point_segment_distance_unit DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("point_segment_distance_unit test failed");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint scale_t(longint t, longint d);
    longint p;
    longint q;
    p = t * d;
    q = (p < 0 ? -p : p) >>> TBits;
    return p < 0 ? -q : q;
  endfunction

  function automatic psd_out_t nearest_distance(psd_in_t it);
    psd_out_t r;
    longint dx, dy, wx, wy, dot, t, rx, ry;
    longint unsigned len2, dist_val;
    dx = longint'(it.seg_end_x) - longint'(it.seg_start_x);
    dy = longint'(it.seg_end_y) - longint'(it.seg_start_y);
    wx = longint'(it.query_x) - longint'(it.seg_start_x);
    wy = longint'(it.query_y) - longint'(it.seg_start_y);
    len2 = dx * dx + dy * dy;
    if (len2 == 0) begin
      r.degenerate = 1'b1;
      t = 0;
      dist_val = int_sqrt(wx * wx + wy * wy);
    end else begin
      r.degenerate = 1'b0;
      dot = wx * dx + wy * dy;
      if (dot <= 0) t = 0;
      else if (longint'(dot) >= longint'(len2)) t = 64'd1 << TBits;
      else t = longint'(($unsigned(dot) << TBits) / len2);
      rx = wx - scale_t(t, dx);
      ry = wy - scale_t(t, dy);
      dist_val = int_sqrt(rx * rx + ry * ry);
    end
    if (dist_val > (64'd1 << DistBits) - 1) dist_val = (64'd1 << DistBits) - 1;
    r.distance = dist_val[DistBits-1:0];
    r.projection_param = t[TOutBits-1:0];
    return r;
  endfunction

  task automatic send_item(psd_in_t it);
    int gap;
    gap = send_gaps ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    distance_queue = {distance_queue, nearest_distance(it)};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_seg(int sx, int sy, int ex, int ey, int px, int py);
    psd_in_t it;
    it.seg_start_x = CoordBits'(sx); it.seg_start_y = CoordBits'(sy);
    it.seg_end_x = CoordBits'(ex); it.seg_end_y = CoordBits'(ey);
    it.query_x = CoordBits'(px); it.query_y = CoordBits'(py);
    send_item(it);
  endtask

  // receiver stall: a wait drawn after each transfer
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if (!stall_random) begin
      out_stall_i <= 1'b0;
    end else if (recv_wait > 0) begin
      out_stall_i <= 1'b1;
      recv_wait <= recv_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (out_valid_o && !out_stall_i)
        recv_wait <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 15)) : 0;
    end
  end

  always @(posedge clk_i) begin
    psd_out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (distance_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        exp_r = distance_queue.pop_front();
        if (out_data_o.distance !== exp_r.distance ||
            out_data_o.projection_param !== exp_r.projection_param ||
            out_data_o.degenerate !== exp_r.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch expected %p actual %p", exp_r, out_data_o);
        end
      end
    end
  end

  task automatic test_directed;
    send_seg(0, 0, 256, 0, 128, 256);
    send_seg(0, 0, 256, 0, -512, 100);
    send_seg(0, 0, 256, 0, 1000, -100);
    send_seg(10, 10, 10, 10, 300, -40);
    send_seg(-32768, -32768, -32768, -32768, 32767, 32767);
    send_seg(-32768, -32768, 32767, 32767, 32767, -32768);
    send_seg(32767, -32768, -32768, 32767, -32768, -32768);
    send_seg(-32768, 0, 32767, 0, 0, 32767);
    send_seg(0, -32768, 0, 32767, -32768, 0);
    send_seg(0, 0, 256, 256, 256, 256);
    send_seg(0, 0, 256, 256, 0, 0);
    send_seg(0, 0, 3, 7, 1, 2);
    send_seg(32767, 32767, 32767, 32767, 32767, 32767);
    send_seg(-1, -1, 1, 1, -1, 1);
    send_seg(100, -200, -300, 400, 5, 5);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 64)) - 32;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic test_random(int n);
    int sx, sy;
    repeat (n) begin
      sx = rand_coord();
      sy = rand_coord();
      if ($urandom_range(0, 15) == 0)
        send_seg(sx, sy, sx, sy, rand_coord(), rand_coord());
      else
        send_seg(sx, sy, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  task automatic test_backpressure;
    int i;
    fork
      begin
        hold_off = 1'b1;
        for (i = 0; i < 150; i++) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_gaps = 1'b0;
        test_random(120);
        send_gaps = 1'b1;
      end
    join
  endtask

  initial begin
    int waited;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    stall_random = 1'b0;
    test_random(300);
    stall_random = 1'b1;
    test_backpressure();
    test_random(1600);
    in_valid_i <= 1'b0;
    waited = 0;
    while (distance_queue.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && distance_queue.size() == 0)
      $display("point_segment_distance_unit test passed");
    else
      $display("point_segment_distance_unit test failed");
    $finish;
  end
endmodule
